FILE: sv/rsra_pkg.sv
// ----------------------------------------------------------------------------
// rsra_pkg
// Types and constants shared by the readback slot ring allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rsra_pkg;

   // request channel layout
   localparam int REQ_DATA_W     = 136;
   localparam int REQ_USER_W     = 2;
   localparam int BYTES_LSB      = 0;
   localparam int TEX_W_LSB      = 32;
   localparam int TEX_H_LSB      = 47;
   localparam int PIX_LSB        = 62;
   localparam int FRAME_LSB      = 67;
   localparam int TEX_DIM_W      = 15;
   localparam int PIX_W          = 5;
   localparam int FRAME_W        = 64;
   localparam int SIZE_W         = 32;
   localparam int PRODUCT_W      = 35;
   localparam int AREA_W         = 30;

   // response channel layout
   localparam int RSP_DATA_W     = 72;
   localparam int KIND_W         = 3;
   localparam int SLOT_IDX_W     = 3;
   localparam int PENDING_W      = 4;
   localparam int RETIRED_W      = 32;
   localparam int RSP_IDX_LSB    = 0;
   localparam int RSP_BYTES_LSB  = 3;
   localparam int RSP_PEND_LSB   = 35;
   localparam int RSP_RET_LSB    = 39;

   // configuration
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 32;
   localparam int FIF_W          = 4;
   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 32'd4194304;
   localparam logic [FIF_W-1:0]  FIF_RESET      = 4'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIZE         = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_FLIGHT = 1'b1;

   // retirements reported by one poll at most
   localparam int MAX_RESULTS    = 8;
   localparam int HITS_W         = 4;

   typedef enum logic [REQ_USER_W-1:0] {
      MODE_BUFFER  = 2'd0,
      MODE_TEXTURE = 2'd1,
      MODE_POLL    = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPTED   = 3'd0,
      KIND_TOO_LARGE  = 3'd1,
      KIND_RING_FULL  = 3'd2,
      KIND_RETIRED    = 3'd3,
      KIND_POLL_EMPTY = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLAIM,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic claim;
      logic eval;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic eligible;
      logic hold_valid;
      logic scan_done;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/rsra_ctrl.sv
// ----------------------------------------------------------------------------
// rsra_ctrl
// Sequencer for requests and polls: accepts a request, steps the slot scan
// and holds off whenever the response register cannot be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module rsra_ctrl (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [rsra_pkg::REQ_USER_W-1:0]      req_mode,
   input  wire rsra_pkg::status_type                 status,
   output rsra_pkg::cmd_type                         cmd
);

   rsra_pkg::state_type state_ff;
   rsra_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rsra_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (req_mode)
                  rsra_pkg::MODE_BUFFER:  state_in = rsra_pkg::ST_CLAIM;
                  rsra_pkg::MODE_TEXTURE: state_in = rsra_pkg::ST_MUL;
                  rsra_pkg::MODE_POLL:    state_in = rsra_pkg::ST_SCAN;
                  default:                state_in = rsra_pkg::ST_IDLE;
               endcase
            end
         end
         rsra_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = rsra_pkg::ST_CLAIM;
         end
         rsra_pkg::ST_CLAIM: begin
            if (!status.out_busy) begin
               cmd.claim = 1'b1;
               state_in  = rsra_pkg::ST_IDLE;
            end
         end
         rsra_pkg::ST_SCAN: begin
            // a second retirement pushes the held one out
            if (!(status.eligible && status.hold_valid && status.out_busy)) begin
               cmd.eval = 1'b1;
               if (status.scan_done) begin
                  state_in = rsra_pkg::ST_FINISH;
               end
            end
         end
         rsra_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = rsra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rsra_pkg::ST_IDLE;
         end
      endcase
   end

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsra_pkg::ST_IDLE) |-> !status.hold_valid)
      else $error("held retirement left over outside a poll");

   a_scan_ends_in_finish: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && status.scan_done) |=> (state_ff == rsra_pkg::ST_FINISH))
      else $error("slot scan did not close the poll");

endmodule

`default_nettype wire

FILE: sv/rsra_dp.sv
// ----------------------------------------------------------------------------
// rsra_dp
// Slot ring datapath: active flags, slot memories, size product, poll scan,
// held retirement and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsra_dp #(
   parameter int RING_SLOTS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [rsra_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [rsra_pkg::REQ_USER_W-1:0]      req_mode,
   input  wire logic                                 csr_we,
   input  wire logic [rsra_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rsra_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire rsra_pkg::cmd_type                    cmd,
   output rsra_pkg::status_type                      status,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [rsra_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic [rsra_pkg::KIND_W-1:0]               rsp_tuser,
   output logic                                      rsp_tlast
);

   localparam int IDX_W    = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int CNT_W    = $clog2(RING_SLOTS + 1);
   localparam int SZ_W     = rsra_pkg::SIZE_W;
   localparam int PROD_W   = rsra_pkg::PRODUCT_W;
   localparam int FR_W     = rsra_pkg::FRAME_W;
   localparam int OIDX_W   = rsra_pkg::SLOT_IDX_W;
   localparam int OPEND_W  = rsra_pkg::PENDING_W;
   localparam int HIT_W    = rsra_pkg::HITS_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_SLOTS - 1);
   localparam logic [HIT_W-1:0] LAST_HIT  = HIT_W'(rsra_pkg::MAX_RESULTS - 1);

   // request fields
   logic [SZ_W-1:0]                     f_bytes;
   logic [rsra_pkg::TEX_DIM_W-1:0]      f_width;
   logic [rsra_pkg::TEX_DIM_W-1:0]      f_height;
   logic [rsra_pkg::PIX_W-1:0]          f_pix;
   logic [FR_W-1:0]                     f_frame;

   assign f_bytes  = req_tdata[rsra_pkg::BYTES_LSB +: SZ_W];
   assign f_width  = req_tdata[rsra_pkg::TEX_W_LSB +: rsra_pkg::TEX_DIM_W];
   assign f_height = req_tdata[rsra_pkg::TEX_H_LSB +: rsra_pkg::TEX_DIM_W];
   assign f_pix    = req_tdata[rsra_pkg::PIX_LSB +: rsra_pkg::PIX_W];
   assign f_frame  = req_tdata[rsra_pkg::FRAME_LSB +: FR_W];

   // registers
   logic [SZ_W-1:0]                 max_size_ff, max_size_in;
   logic [rsra_pkg::FIF_W-1:0]      fif_ff, fif_in;
   logic [RING_SLOTS-1:0]           active_ff, active_in;
   logic [IDX_W-1:0]                next_slot_ff, next_slot_in;
   logic [CNT_W-1:0]                pending_ff, pending_in;
   logic [rsra_pkg::RETIRED_W-1:0]  retired_ff, retired_in;
   logic [FR_W-1:0]                 cur_frame_ff, cur_frame_in;
   logic [PROD_W-1:0]               size_ff, size_in;
   logic [rsra_pkg::AREA_W-1:0]     area_ff, area_in;
   logic [rsra_pkg::PIX_W-1:0]      pix_ff, pix_in;
   logic [IDX_W-1:0]                scan_idx_ff, scan_idx_in;
   logic [HIT_W-1:0]                hits_ff, hits_in;

   logic                            hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0]                hold_idx_ff, hold_idx_in;
   logic [SZ_W-1:0]                 hold_bytes_ff, hold_bytes_in;
   logic [CNT_W-1:0]                hold_pend_ff, hold_pend_in;
   logic [rsra_pkg::RETIRED_W-1:0]  hold_ret_ff, hold_ret_in;

   logic                            out_valid_ff, out_valid_in;
   rsra_pkg::kind_type              out_kind_ff, out_kind_in;
   logic [OIDX_W-1:0]               out_idx_ff, out_idx_in;
   logic [SZ_W-1:0]                 out_bytes_ff, out_bytes_in;
   logic [OPEND_W-1:0]              out_pend_ff, out_pend_in;
   logic [rsra_pkg::RETIRED_W-1:0]  out_ret_ff, out_ret_in;
   logic                            out_last_ff, out_last_in;
   logic                            out_load;

   // slot memories
   logic [SZ_W-1:0]                 slot_size_mem [RING_SLOTS];
   logic [FR_W-1:0]                 slot_frame_mem [RING_SLOTS];
   logic [SZ_W-1:0]                 rd_size_ff;
   logic [FR_W-1:0]                 rd_frame_ff;
   logic                            mem_we;

   // free slot search and eligibility
   logic                            free_hi, free_lo;
   logic [IDX_W-1:0]                free_hi_idx, free_lo_idx, free_idx;
   logic                            too_large;
   logic                            eligible;

   always_comb begin
      free_hi     = 1'b0;
      free_lo     = 1'b0;
      free_hi_idx = '0;
      free_lo_idx = '0;
      for (int i = RING_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_lo     = 1'b1;
            free_lo_idx = IDX_W'(i);
            if (i >= int'(next_slot_ff)) begin
               free_hi     = 1'b1;
               free_hi_idx = IDX_W'(i);
            end
         end
      end
      free_idx = free_hi ? free_hi_idx : free_lo_idx;
   end

   assign too_large = size_ff > {{(PROD_W - SZ_W){1'b0}}, max_size_ff};
   assign eligible  = active_ff[scan_idx_ff] &&
                      ({1'b0, cur_frame_ff} >= ({1'b0, rd_frame_ff} + (FR_W + 1)'(fif_ff)));

   assign status.out_busy   = out_valid_ff && !rsp_tready;
   assign status.eligible   = eligible;
   assign status.hold_valid = hold_valid_ff;
   assign status.scan_done  = (scan_idx_ff == LAST_IDX) || (eligible && hits_ff == LAST_HIT);

   always_comb begin
      max_size_in   = max_size_ff;
      fif_in        = fif_ff;
      active_in     = active_ff;
      next_slot_in  = next_slot_ff;
      pending_in    = pending_ff;
      retired_in    = retired_ff;
      cur_frame_in  = cur_frame_ff;
      size_in       = size_ff;
      area_in       = area_ff;
      pix_in        = pix_ff;
      scan_idx_in   = scan_idx_ff;
      hits_in       = hits_ff;
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      hold_bytes_in = hold_bytes_ff;
      hold_pend_in  = hold_pend_ff;
      hold_ret_in   = hold_ret_ff;
      out_load      = 1'b0;
      out_kind_in   = out_kind_ff;
      out_idx_in    = out_idx_ff;
      out_bytes_in  = out_bytes_ff;
      out_pend_in   = out_pend_ff;
      out_ret_in    = out_ret_ff;
      out_last_in   = out_last_ff;
      mem_we        = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            rsra_pkg::CSR_MAX_SIZE:         max_size_in = csr_wdata;
            rsra_pkg::CSR_FRAMES_IN_FLIGHT: fif_in      = csr_wdata[rsra_pkg::FIF_W-1:0];
            default:                        max_size_in = max_size_ff;
         endcase
      end

      if (cmd.capture) begin
         unique case (req_mode)
            rsra_pkg::MODE_BUFFER: begin
               size_in = PROD_W'(f_bytes);
            end
            rsra_pkg::MODE_TEXTURE: begin
               area_in = f_width * f_height;
               pix_in  = f_pix;
            end
            rsra_pkg::MODE_POLL: begin
               cur_frame_in = f_frame;
               scan_idx_in  = '0;
               hits_in      = '0;
            end
            default: begin
               size_in = size_ff;
            end
         endcase
      end

      if (cmd.mul) begin
         size_in = PROD_W'(area_ff) * PROD_W'(pix_ff);
      end

      if (cmd.claim) begin
         out_load    = 1'b1;
         out_last_in = 1'b1;
         out_ret_in  = retired_ff;
         out_idx_in  = '0;
         out_bytes_in = '0;
         out_pend_in = OPEND_W'(pending_ff);
         if (too_large) begin
            out_kind_in = rsra_pkg::KIND_TOO_LARGE;
         end else if (free_lo) begin
            mem_we              = 1'b1;
            active_in[free_idx] = 1'b1;
            next_slot_in        = (free_idx == LAST_IDX) ? '0 : free_idx + 1'b1;
            pending_in          = pending_ff + 1'b1;
            out_kind_in         = rsra_pkg::KIND_ACCEPTED;
            out_idx_in          = OIDX_W'(free_idx);
            out_bytes_in        = size_ff[SZ_W-1:0];
            out_pend_in         = OPEND_W'(pending_ff + 1'b1);
         end else begin
            out_kind_in = rsra_pkg::KIND_RING_FULL;
         end
      end

      if (cmd.eval) begin
         if (scan_idx_ff != LAST_IDX) begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         if (eligible) begin
            active_in[scan_idx_ff] = 1'b0;
            pending_in    = pending_ff - 1'b1;
            retired_in    = retired_ff + 1'b1;
            hits_in       = hits_ff + 1'b1;
            hold_valid_in = 1'b1;
            hold_idx_in   = scan_idx_ff;
            hold_bytes_in = rd_size_ff;
            hold_pend_in  = pending_ff - 1'b1;
            hold_ret_in   = retired_ff + 1'b1;
            if (hold_valid_ff) begin
               out_load     = 1'b1;
               out_kind_in  = rsra_pkg::KIND_RETIRED;
               out_idx_in   = OIDX_W'(hold_idx_ff);
               out_bytes_in = hold_bytes_ff;
               out_pend_in  = OPEND_W'(hold_pend_ff);
               out_ret_in   = hold_ret_ff;
               out_last_in  = 1'b0;
            end
         end
      end

      if (cmd.finish) begin
         out_load      = 1'b1;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
         if (hold_valid_ff) begin
            out_kind_in  = rsra_pkg::KIND_RETIRED;
            out_idx_in   = OIDX_W'(hold_idx_ff);
            out_bytes_in = hold_bytes_ff;
            out_pend_in  = OPEND_W'(hold_pend_ff);
            out_ret_in   = hold_ret_ff;
         end else begin
            out_kind_in  = rsra_pkg::KIND_POLL_EMPTY;
            out_idx_in   = '0;
            out_bytes_in = '0;
            out_pend_in  = OPEND_W'(pending_ff);
            out_ret_in   = retired_ff;
         end
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff   <= rsra_pkg::MAX_SIZE_RESET;
         fif_ff        <= rsra_pkg::FIF_RESET;
         active_ff     <= '0;
         next_slot_ff  <= '0;
         pending_ff    <= '0;
         retired_ff    <= '0;
         cur_frame_ff  <= '0;
         scan_idx_ff   <= '0;
         hits_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         max_size_ff   <= max_size_in;
         fif_ff        <= fif_in;
         active_ff     <= active_in;
         next_slot_ff  <= next_slot_in;
         pending_ff    <= pending_in;
         retired_ff    <= retired_in;
         cur_frame_ff  <= cur_frame_in;
         scan_idx_ff   <= scan_idx_in;
         hits_ff       <= hits_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      area_ff       <= area_in;
      pix_ff        <= pix_in;
      hold_idx_ff   <= hold_idx_in;
      hold_bytes_ff <= hold_bytes_in;
      hold_pend_ff  <= hold_pend_in;
      hold_ret_ff   <= hold_ret_in;
      out_kind_ff   <= out_kind_in;
      out_idx_ff    <= out_idx_in;
      out_bytes_ff  <= out_bytes_in;
      out_pend_ff   <= out_pend_in;
      out_ret_ff    <= out_ret_in;
      out_last_ff   <= out_last_in;
   end

   // slot memories, read address follows the scan pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_size_mem[free_idx]  <= size_ff[SZ_W-1:0];
         slot_frame_mem[free_idx] <= cur_frame_ff;
      end
      rd_size_ff  <= slot_size_mem[scan_idx_in];
      rd_frame_ff <= slot_frame_mem[scan_idx_in];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_ret_ff, out_pend_ff, out_bytes_ff, out_idx_ff};

   a_pending_matches: assert property (@(posedge clock) disable iff (reset)
      pending_ff == CNT_W'($countones(active_ff)))
      else $error("pending count out of step with active slots");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_valid_ff) |-> rsp_tready)
      else $error("response register overwritten before it was taken");

   a_retire_in_scan: assert property (@(posedge clock) disable iff (reset)
      !$stable(retired_ff) |-> $past(cmd.eval))
      else $error("retired count moved outside the slot scan");

endmodule

`default_nettype wire

FILE: sv/readback_slot_ring_allocator.sv
// ----------------------------------------------------------------------------
// readback_slot_ring_allocator
// Ring of readback slots claimed by buffer and texture requests and retired
// by frame polls once they are old enough.
// ----------------------------------------------------------------------------
// One request at a time. A buffer request goes straight to the claim; a texture
// request first forms the width x height x bytes-per-pixel product over two
// registered multiplies. Each ends in one response. The poll scan reads one
// slot's frame stamp and size per cycle from the slot memories unless stalled
// by a full response register, and compares its age; every retired slot gives
// one response, the final one marked by tlast (none retired: one poll-empty
// response). Responses sit in an output register, so the next request is taken
// while the previous one's last response waits; only a full, untaken register stalls.
`default_nettype none

module readback_slot_ring_allocator #(
   parameter int RING_SLOTS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // byte_count, tex_width, tex_height, pixel_bytes, frame_number, zero fill
   input  wire logic [rsra_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode
   input  wire logic [rsra_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // slot_index, slot_bytes, pending_slots, retired_total, zero fill
   output logic [rsra_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   // kind
   output logic [rsra_pkg::KIND_W-1:0]               rsp_tuser,
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_we,
   input  wire logic [rsra_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [rsra_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   rsra_pkg::cmd_type    cmd;
   rsra_pkg::status_type status;

   rsra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   rsra_dp #(
      .RING_SLOTS (RING_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_mode   (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
